@@ sv/crps_pkg.sv @@
// ----------------------------------------------------------------------------
// crps_pkg
// Shared types and constants for the Catmull-Rom path smoother.
// ----------------------------------------------------------------------------
package crps_pkg;

    // Fixed field widths
    localparam int IN_W     = 10;
    localparam int SAMPLE_W = 20;
    localparam int S_W      = 5;
    localparam int SQ_W     = 10;
    localparam int CUBE_W   = 15;
    localparam int DEN_W    = 16;

    localparam logic [S_W-1:0] S_MAX   = 5'd30;
    localparam logic [S_W-1:0] S_MIN   = 5'd1;
    localparam logic [S_W-1:0] S_RESET = 5'd10;

    localparam int SAMPLE_MAX = 524287;
    localparam int SAMPLE_MIN = -524288;

    typedef struct packed {
        logic [IN_W-1:0] point_x;
        logic [IN_W-1:0] point_y;
        logic            final_point;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic                       end_of_path;
        logic                       no_path;
    } out_item_t;

    // Multiply-accumulate steps of the Horner evaluation
    typedef enum logic [2:0] {
        MAC_NONE,
        MAC_CJ,
        MAC_BS,
        MAC_ACCJ,
        MAC_AS2,
        MAC_PS3
    } mac_op_t;

    // Source of an output sample
    typedef enum logic [1:0] {
        SRC_DIV,
        SRC_POINT,
        SRC_ZERO
    } res_src_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SQ,
        ST_CUBE,
        ST_LOAD,
        ST_CJ,
        ST_BS,
        ST_MJ1,
        ST_AS2,
        ST_MJ2,
        ST_PS3,
        ST_PREP,
        ST_ABS,
        ST_DIV,
        ST_RES,
        ST_POINT,
        ST_EMPTY
    } state_t;

    // Commands from the controller to both coordinate lanes
    typedef struct packed {
        logic                 cap_in;
        logic                 load_seg;
        logic                 seg_last;
        logic                 p0_dup;
        logic                 shift_hist;
        mac_op_t              mac;
        logic                 prep;
        logic                 absv;
        logic                 div_step;
        logic                 res_load;
        res_src_t             res_src;
        logic [S_W-1:0]       s;
        logic [SQ_W-1:0]      s2;
        logic [CUBE_W-1:0]    s3;
        logic [S_W-1:0]       j;
    } ctrl_cmd_t;

endpackage

@@ sv/catmull_rom_path_smoother.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_path_smoother
// Uniform Catmull-Rom smoothing of a waypoint stream into fixed-point samples.
// ----------------------------------------------------------------------------
// Waypoints are taken one at a time, and the block takes no new waypoint until
// every sample it causes has been produced. Each sample takes six
// multiply-accumulate steps, two rounding-prep steps, one cycle per quotient bit
// in the shift-subtract divider (COORD_BITS+FRAC_BITS+20 bits) and one
// saturation step; x and y run in parallel. A waypoint that closes a segment
// yields S+1 samples, the final waypoint up to 2S+3. The last sample sits in
// the output register while the next waypoint is accepted.
module catmull_rom_path_smoother #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  crps_pkg::in_item_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output crps_pkg::out_item_t       out_data,
    input  logic                      cfg_write_en,
    input  logic [crps_pkg::S_W-1:0]  cfg_write_data
);
    import crps_pkg::*;

    localparam int DIV_STEPS = COORD_BITS + FRAC_BITS + 20;

    ctrl_cmd_t                  cmd;
    logic                       eop, nop;
    logic signed [SAMPLE_W-1:0] sx, sy;

    crps_ctrl #(
        .DIV_STEPS(DIV_STEPS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .final_point    (in_data.final_point),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .end_of_path    (eop),
        .no_path        (nop),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd)
    );

    crps_lane #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .coord_in (in_data.point_x),
        .sample   (sx)
    );

    crps_lane #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .coord_in (in_data.point_y),
        .sample   (sy)
    );

    // Output transfer payload
    assign out_data = {sx, sy, eop, nop};

endmodule

@@ sv/crps_lane.sv @@
// ----------------------------------------------------------------------------
// crps_lane
// Datapath for one coordinate: waypoint history, spline coefficients,
// Horner multiply-accumulate, rounding prep, bit-serial divider, saturation.
// ----------------------------------------------------------------------------
module crps_lane #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  crps_pkg::ctrl_cmd_t               cmd,
    input  logic [crps_pkg::IN_W-1:0]         coord_in,
    output logic signed [crps_pkg::SAMPLE_W-1:0] sample
);
    import crps_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int CW    = CB + 4;
    localparam int ACC_W = CB + 20;
    localparam int MAG_W = CB + FRAC_BITS + 20;
    localparam int NUM_W = MAG_W + 1;
    localparam int RES_W = MAG_W + 1;
    localparam int PRD_W = ACC_W + CUBE_W + 1;

    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(SAMPLE_MAX);
    localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(SAMPLE_MIN);

    logic [CB-1:0]              in_reg;
    logic [CB-1:0]              hist_reg [3];
    logic signed [CW-1:0]       a_reg, b_reg, c_reg, p1x2_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic [MAG_W-1:0]           quo_reg;
    logic [DEN_W-1:0]           rem_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [CB-1:0]              p0, p1, p2, p3;
    logic signed [CW-1:0]       p0s, p1s, p2s, p3s;
    logic signed [ACC_W-1:0]    opa, base;
    logic [CUBE_W-1:0]          opb;
    logic signed [PRD_W-1:0]    prod;
    logic [DEN_W-1:0]           den;
    logic [NUM_W-1:0]           mag_neg;
    logic [DEN_W:0]             rem_w;
    logic                       ge;
    logic signed [RES_W-1:0]    divres, sat_in;

    // Control points of the current segment
    always_comb
    begin
        p1  = cmd.seg_last ? hist_reg[0] : hist_reg[1];
        p2  = cmd.seg_last ? in_reg : hist_reg[0];
        p3  = in_reg;
        p0  = cmd.p0_dup ? p1 : (cmd.seg_last ? hist_reg[1] : hist_reg[2]);
        p0s = $signed(CW'(p0));
        p1s = $signed(CW'(p1));
        p2s = $signed(CW'(p2));
        p3s = $signed(CW'(p3));
    end

    // Horner operand selection
    always_comb
    begin
        opa  = '0;
        opb  = '0;
        base = '0;
        case (cmd.mac)
            MAC_CJ:
            begin
                opa = ACC_W'(c_reg);
                opb = CUBE_W'(cmd.j);
            end
            MAC_BS:
            begin
                opa  = ACC_W'(b_reg);
                opb  = CUBE_W'(cmd.s);
                base = acc_reg;
            end
            MAC_ACCJ:
            begin
                opa = acc_reg;
                opb = CUBE_W'(cmd.j);
            end
            MAC_AS2:
            begin
                opa  = ACC_W'(a_reg);
                opb  = CUBE_W'(cmd.s2);
                base = acc_reg;
            end
            MAC_PS3:
            begin
                opa  = ACC_W'(p1x2_reg);
                opb  = cmd.s3;
                base = acc_reg;
            end
            default:
            begin
                opa = '0;
            end
        endcase
        prod = opa * $signed({1'b0, opb});
    end

    // Divider helpers
    assign den     = {cmd.s3, 1'b0};
    assign mag_neg = NUM_W'(0) - num_reg + NUM_W'(den) - NUM_W'(1);
    assign rem_w   = {rem_reg, quo_reg[MAG_W-1]};
    assign ge      = rem_w >= {1'b0, den};

    // Result selection and saturation
    always_comb
    begin
        divres = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        case (cmd.res_src)
            SRC_DIV:   sat_in = divres;
            SRC_POINT: sat_in = $signed(RES_W'({in_reg, {FRAC_BITS{1'b0}}}));
            default:   sat_in = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
        end
        else if (cmd.shift_hist)
        begin
            hist_reg[2] <= hist_reg[1];
            hist_reg[1] <= hist_reg[0];
            hist_reg[0] <= in_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
            in_reg <= CB'(coord_in);
        if (cmd.load_seg)
        begin
            a_reg    <= p2s - p0s;
            b_reg    <= (p0s <<< 1) - (p1s <<< 2) - p1s + (p2s <<< 2) - p3s;
            c_reg    <= (p1s <<< 1) + p1s - p0s - (p2s <<< 1) - p2s + p3s;
            p1x2_reg <= p1s <<< 1;
        end
        if (cmd.mac != MAC_NONE)
            acc_reg <= base + prod[ACC_W-1:0];
        // N * 2^F + S^3
        if (cmd.prep)
            num_reg <= $signed({acc_reg[ACC_W-1], acc_reg, {FRAC_BITS{1'b0}}})
                       + $signed(NUM_W'(cmd.s3));
        // floor division of a negative value via ceil of the magnitude
        if (cmd.absv)
        begin
            neg_reg <= num_reg[NUM_W-1];
            quo_reg <= num_reg[NUM_W-1] ? mag_neg[MAG_W-1:0] : num_reg[MAG_W-1:0];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? DEN_W'(rem_w - {1'b0, den}) : rem_w[DEN_W-1:0];
            quo_reg <= {quo_reg[MAG_W-2:0], ge};
        end
        if (cmd.res_load)
        begin
            if (sat_in > SAT_HI)
                sample_reg <= SAT_HI[SAMPLE_W-1:0];
            else if (sat_in < SAT_LO)
                sample_reg <= SAT_LO[SAMPLE_W-1:0];
            else
                sample_reg <= sat_in[SAMPLE_W-1:0];
        end
    end

    assign sample = sample_reg;

endmodule

@@ sv/crps_ctrl.sv @@
// ----------------------------------------------------------------------------
// crps_ctrl
// Sequencer: path bookkeeping, segment and sample loop, divider count,
// configuration register and the output flag register.
// ----------------------------------------------------------------------------
module crps_ctrl #(
    parameter int DIV_STEPS = 38
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         final_point,
    output logic                         in_stall,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         end_of_path,
    output logic                         no_path,
    input  logic                         cfg_write_en,
    input  logic [crps_pkg::S_W-1:0]     cfg_write_data,
    output crps_pkg::ctrl_cmd_t          cmd
);
    import crps_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t             state_reg, state_next;
    logic [1:0]         ps_reg, ps_next;
    logic               fin_reg, fin_next;
    logic               seg_last_reg, seg_last_next;
    logic [S_W-1:0]     j_reg, j_next;
    logic [SQ_W-1:0]    s2_reg, s2_next;
    logic [CUBE_W-1:0]  s3_reg, s3_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [S_W-1:0]     cfg_s_reg;
    logic               out_valid_reg, eop_reg, nop_reg;
    logic [S_W-1:0]     s_eff;
    logic               out_free, seg_done;

    assign s_eff    = (cfg_s_reg < S_MIN) ? S_MIN :
                      ((cfg_s_reg > S_MAX) ? S_MAX : cfg_s_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign seg_done = (j_reg == s_eff);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (fin_reg && ps_reg == 2'd0)
                    state_next = ST_EMPTY;
                else if (ps_reg >= 2'd2 || fin_reg)
                    state_next = ST_SQ;
                else
                    state_next = ST_IDLE;
            end
            ST_SQ:     state_next = ST_CUBE;
            ST_CUBE:   state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_CJ;
            ST_CJ:     state_next = ST_BS;
            ST_BS:     state_next = ST_MJ1;
            ST_MJ1:    state_next = ST_AS2;
            ST_AS2:    state_next = ST_MJ2;
            ST_MJ2:    state_next = ST_PS3;
            ST_PS3:    state_next = ST_PREP;
            ST_PREP:   state_next = ST_ABS;
            ST_ABS:    state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == CNT_LAST) state_next = ST_RES;
            ST_RES:
            begin
                if (out_free)
                begin
                    if (!seg_done)
                        state_next = ST_CJ;
                    else if (seg_last_reg)
                        state_next = ST_POINT;
                    else if (fin_reg)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_POINT:  if (out_free) state_next = ST_IDLE;
            ST_EMPTY:  if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.mac      = MAC_NONE;
        cmd.res_src  = SRC_DIV;
        cmd.seg_last = seg_last_reg;
        cmd.p0_dup   = seg_last_reg ? (ps_reg == 2'd1) : (ps_reg == 2'd2);
        cmd.s        = s_eff;
        cmd.s2       = s2_reg;
        cmd.s3       = s3_reg;
        cmd.j        = j_reg;
        unique case (state_reg)
            ST_IDLE:   cmd.cap_in = in_valid;
            ST_DECIDE: cmd.shift_hist = !fin_reg && ps_reg < 2'd2;
            ST_LOAD:   cmd.load_seg = 1'b1;
            ST_CJ:     cmd.mac = MAC_CJ;
            ST_BS:     cmd.mac = MAC_BS;
            ST_MJ1:    cmd.mac = MAC_ACCJ;
            ST_AS2:    cmd.mac = MAC_AS2;
            ST_MJ2:    cmd.mac = MAC_ACCJ;
            ST_PS3:    cmd.mac = MAC_PS3;
            ST_PREP:   cmd.prep = 1'b1;
            ST_ABS:    cmd.absv = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_RES:
            begin
                cmd.res_load   = out_free;
                cmd.shift_hist = out_free && seg_done && !seg_last_reg && !fin_reg;
            end
            ST_POINT:
            begin
                cmd.res_load = out_free;
                cmd.res_src  = SRC_POINT;
            end
            ST_EMPTY:
            begin
                cmd.res_load = out_free;
                cmd.res_src  = SRC_ZERO;
            end
            default:   cmd.cap_in = 1'b0;
        endcase
    end

    // Counters and bookkeeping
    always_comb
    begin
        ps_next       = ps_reg;
        fin_next      = fin_reg;
        seg_last_next = seg_last_reg;
        j_next        = j_reg;
        s2_next       = s2_reg;
        s3_next       = s3_reg;
        cnt_next      = cnt_reg;
        if (cmd.cap_in)
            fin_next = final_point;
        if (cmd.shift_hist && ps_reg != 2'd3)
            ps_next = ps_reg + 2'd1;
        case (state_reg)
            ST_DECIDE: seg_last_next = ps_reg < 2'd2;
            ST_SQ:     s2_next = SQ_W'(s_eff * s_eff);
            ST_CUBE:   s3_next = CUBE_W'(s2_reg * s_eff);
            ST_LOAD:   j_next = '0;
            ST_ABS:    cnt_next = '0;
            ST_DIV:    cnt_next = cnt_reg + CNT_W'(1);
            ST_RES:
            begin
                if (out_free)
                begin
                    if (!seg_done)
                        j_next = j_reg + S_W'(1);
                    else if (!seg_last_reg && fin_reg)
                        seg_last_next = 1'b1;
                end
            end
            ST_POINT:  if (out_free) ps_next = 2'd0;
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ps_reg        <= 2'd0;
            fin_reg       <= 1'b0;
            seg_last_reg  <= 1'b0;
            j_reg         <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            cnt_reg       <= '0;
            cfg_s_reg     <= S_RESET;
            out_valid_reg <= 1'b0;
            eop_reg       <= 1'b0;
            nop_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ps_reg       <= ps_next;
            fin_reg      <= fin_next;
            seg_last_reg <= seg_last_next;
            j_reg        <= j_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            cnt_reg      <= cnt_next;
            if (cfg_write_en)
                cfg_s_reg <= cfg_write_data;
            // output register: load a new transfer or retire the taken one
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
                eop_reg       <= cmd.res_src != SRC_DIV;
                nop_reg       <= cmd.res_src == SRC_ZERO;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_stall    = state_reg != ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign end_of_path = eop_reg;
    assign no_path     = nop_reg;

    // Sample index stays within the segment while evaluating
    a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CJ) |-> (j_reg <= s_eff))
        else $error("sample index beyond segment");

    // Finishing a path clears the point count
    a_path_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POINT && out_free) |=> (ps_reg == 2'd0))
        else $error("point count not cleared after path end");

    // An empty-path result is always the last of its path
    a_nop_eop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && nop_reg) |-> eop_reg)
        else $error("no_path without end_of_path");

endmodule
